>>> rtl/tlg_pkg.sv
// Shared constants, types and the back-end state encoding for tile_luma_to_glyph.
// Used by the front end, queue, back end and top level; depends on nothing.
package tlg_pkg;

  // Sizing
  localparam int unsigned MAX_TILE_PIXELS = 1024;
  localparam int unsigned TABLE_DEPTH     = 255;

  localparam int unsigned LUMA_W  = 24;                               // Q8.16 luma
  localparam int unsigned CNT_W   = $clog2(MAX_TILE_PIXELS + 1);
  localparam int unsigned SUM_W   = LUMA_W + $clog2(MAX_TILE_PIXELS);
  localparam int unsigned TBL_AW  = $clog2(TABLE_DEPTH);
  localparam int unsigned AVG_W   = 8;
  localparam int unsigned STEP_W  = $clog2(AVG_W);
  localparam int unsigned DIV_W   = CNT_W + LUMA_W;
  localparam int unsigned DIV_SH  = LUMA_W - 1;                       // top quotient bit
  localparam int unsigned SQ_W    = 2 * AVG_W;
  localparam int unsigned CUBE_W  = 3 * AVG_W;

  // Rec.709 weights in Q0.16, summing to exactly 1.0
  localparam logic [15:0] COEF_R = 16'd13933;
  localparam logic [15:0] COEF_G = 16'd46871;
  localparam logic [15:0] COEF_B = 16'd4732;

  // floor(x / 65025) == (x * RECIP_M) >> RECIP_SH for every x below 2^24
  localparam int unsigned RECIP_W  = 25;
  localparam logic [RECIP_W-1:0] RECIP_M = 25'd16909061;
  localparam int unsigned RECIP_SH = 40;
  localparam int unsigned PROD_W   = CUBE_W + RECIP_W;

  // Queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned Q_AW        = $clog2(QUEUE_DEPTH);

  // One queued job: a table write or a finished tile
  typedef struct packed {
    logic              is_write;
    logic [SUM_W-1:0]  sum;
    logic [CNT_W-1:0]  cnt;
    logic [7:0]        tidx;
    logic [7:0]        glyph;
  } q_entry_t;

  // Queue status seen by the front
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_DIV   = 7'b0000010,
    ST_SQR   = 7'b0000100,
    ST_CUBE  = 7'b0001000,
    ST_SCALE = 7'b0010000,
    ST_INDEX = 7'b0100000,
    ST_READ  = 7'b1000000
  } back_state_e;

endpackage

>>> rtl/tlg_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package needed.
module tlg_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/tlg_front.sv
// Front end: accepts words, computes the pixel luma, accumulates the tile and
// pushes table writes and finished tiles into the queue. Depends on tlg_pkg.
module tlg_front import tlg_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       cmd_i,
  input  logic [7:0] table_index_i,
  input  logic [7:0] table_glyph_i,
  input  logic [7:0] red_i,
  input  logic [7:0] green_i,
  input  logic [7:0] blue_i,
  input  logic       tile_last_i,
  input  q_status_t  q_status_i,
  output logic       push_o,
  output q_entry_t   push_entry_o
);

  // Stage 1 holding register
  logic              s1_valid_q, s1_valid_d;
  logic              s1_write_q;
  logic              s1_last_q;
  logic [LUMA_W-1:0] s1_luma_q;
  logic [7:0]        s1_tidx_q;
  logic [7:0]        s1_glyph_q;

  // Tile accumulator
  logic [SUM_W-1:0]  sum_q, sum_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;

  logic              accept;
  logic              needs_push;
  logic              s1_fire;
  logic              acc_en;
  logic [LUMA_W-1:0] luma;
  logic [SUM_W-1:0]  sum_new;
  logic [CNT_W-1:0]  cnt_new;

  // Luma of the incoming pixel, Q8.16
  assign luma = LUMA_W'(COEF_R) * LUMA_W'(red_i)
              + LUMA_W'(COEF_G) * LUMA_W'(green_i)
              + LUMA_W'(COEF_B) * LUMA_W'(blue_i);

  // Out-of-range table writes are simply dropped
  assign needs_push = s1_write_q ? ({1'b0, s1_tidx_q} < 9'(TABLE_DEPTH)) : s1_last_q;
  assign s1_fire    = s1_valid_q && !(needs_push && q_status_i.full);
  assign in_stall_o = s1_valid_q && !s1_fire;
  assign accept     = in_valid_i && !in_stall_o;

  // Accumulate, saturating the tile length
  assign acc_en  = cnt_q < CNT_W'(MAX_TILE_PIXELS);
  assign sum_new = acc_en ? (sum_q + SUM_W'(s1_luma_q)) : sum_q;
  assign cnt_new = acc_en ? (cnt_q + CNT_W'(1)) : cnt_q;

  always_comb begin
    sum_d = sum_q;
    cnt_d = cnt_q;
    if (s1_fire && !s1_write_q) begin
      if (s1_last_q) begin
        sum_d = '0;
        cnt_d = '0;
      end else begin
        sum_d = sum_new;
        cnt_d = cnt_new;
      end
    end
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_fire) begin
      s1_valid_d = 1'b0;
    end
  end

  // Queue push
  assign push_o             = s1_fire && needs_push;
  assign push_entry_o.is_write = s1_write_q;
  assign push_entry_o.sum   = sum_new;
  assign push_entry_o.cnt   = cnt_new;
  assign push_entry_o.tidx  = s1_tidx_q;
  assign push_entry_o.glyph = s1_glyph_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      sum_q      <= '0;
      cnt_q      <= '0;
    end else begin
      s1_valid_q <= s1_valid_d;
      sum_q      <= sum_d;
      cnt_q      <= cnt_d;
    end
  end

  // Stage 1 payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_write_q <= !cmd_i;
      s1_last_q  <= tile_last_i;
      s1_luma_q  <= luma;
      s1_tidx_q  <= table_index_i;
      s1_glyph_q <= table_glyph_i;
    end
  end

endmodule

>>> rtl/tlg_queue.sv
// Short FIFO of jobs between the front and back ends, held in flops.
// Depends on tlg_pkg.
module tlg_queue import tlg_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  q_entry_t  push_entry_i,
  input  logic      pop_i,
  output q_entry_t  head_o,
  output q_status_t status_o
);

  q_entry_t        entry_q [QUEUE_DEPTH];
  logic [Q_AW-1:0] wptr_q, rptr_q;
  logic [Q_AW:0]   fill_q, fill_d;
  logic            do_push, do_pop;

  assign status_o.full  = fill_q == (Q_AW+1)'(QUEUE_DEPTH);
  assign status_o.empty = fill_q == '0;
  assign do_push = push_i && !status_o.full;
  assign do_pop  = pop_i && !status_o.empty;
  assign head_o  = entry_q[rptr_q];

  always_comb begin
    fill_d = fill_q;
    if (do_push && !do_pop) begin
      fill_d = fill_q + (Q_AW+1)'(1);
    end else if (do_pop && !do_push) begin
      fill_d = fill_q - (Q_AW+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      fill_q <= '0;
    end else begin
      fill_q <= fill_d;
      if (do_push) begin
        wptr_q <= wptr_q + Q_AW'(1);
      end
      if (do_pop) begin
        rptr_q <= rptr_q + Q_AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wptr_q] <= push_entry_i;
    end
  end

endmodule

>>> rtl/tlg_back.sv
// Back end: executes queued jobs - table writes, and for a tile the average
// divide, cube curve, clamp and glyph lookup. Depends on tlg_pkg and tlg_ram.
module tlg_back import tlg_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  q_entry_t   head_i,
  input  q_status_t  q_status_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] glyph_code_o
);

  back_state_e        state_q, state_d;
  logic               out_valid_q, out_valid_d;
  logic [7:0]         glyph_q;
  logic [DIV_W-1:0]   rem_q;
  logic [DIV_W-1:0]   div_q;
  logic [AVG_W-1:0]   avg_q;
  logic [STEP_W-1:0]  step_q;
  logic [SQ_W-1:0]    sq_q;
  logic [CUBE_W-1:0]  cube_q;
  logic [PROD_W-1:0]  prod_q;

  logic               ram_we;
  logic               ram_re;
  logic [TBL_AW-1:0]  ram_raddr;
  logic [7:0]         ram_rdata;
  logic               rem_ge;
  logic [7:0]         idx_raw;
  logic [7:0]         idx_clamped;
  logic               out_load;

  tlg_ram #(
    .WIDTH (8),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (head_i.tidx[TBL_AW-1:0]),
    .wdata_i (head_i.glyph),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // One restoring-divide step: quotient bits come out MSB first
  assign rem_ge = rem_q >= div_q;

  // Cube curve index, clamped to the last table entry
  assign idx_raw     = prod_q[RECIP_SH +: 8];
  assign idx_clamped = (9'(idx_raw) > 9'(TABLE_DEPTH - 1)) ? 8'(TABLE_DEPTH - 1) : idx_raw;
  assign ram_raddr   = idx_clamped[TBL_AW-1:0];

  assign pop_o    = (state_q == ST_IDLE) && !q_status_i.empty;
  assign ram_we   = pop_o && head_i.is_write;
  assign ram_re   = state_q == ST_INDEX;
  assign out_load = (state_q == ST_READ) && (!out_valid_q || !out_stall_i);

  // Sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (pop_o && !head_i.is_write) begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (step_q == '0) begin
          state_d = ST_SQR;
        end
      end
      ST_SQR:   state_d = ST_CUBE;
      ST_CUBE:  state_d = ST_SCALE;
      ST_SCALE: state_d = ST_INDEX;
      ST_INDEX: state_d = ST_READ;
      ST_READ: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  // Output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        rem_q  <= DIV_W'(head_i.sum);
        div_q  <= DIV_W'({head_i.cnt, {DIV_SH{1'b0}}});
        step_q <= STEP_W'(AVG_W - 1);
      end
      ST_DIV: begin
        if (rem_ge) begin
          rem_q <= rem_q - div_q;
        end
        avg_q  <= {avg_q[AVG_W-2:0], rem_ge};
        div_q  <= div_q >> 1;
        step_q <= step_q - STEP_W'(1);
      end
      ST_SQR:   sq_q   <= SQ_W'(avg_q) * SQ_W'(avg_q);
      ST_CUBE:  cube_q <= CUBE_W'(sq_q) * CUBE_W'(avg_q);
      ST_SCALE: prod_q <= PROD_W'(cube_q) * PROD_W'(RECIP_M);
      default: begin
      end
    endcase
    if (out_load) begin
      glyph_q <= ram_rdata;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign glyph_code_o = glyph_q;

endmodule

>>> rtl/tile_luma_to_glyph.sv
// Top level of tile_luma_to_glyph: front end, job queue and back end.
// Depends on tlg_pkg, tlg_front, tlg_queue, tlg_back and tlg_ram.
//
// Takes one word per clock unless stalled: a glyph-table write (cmd 0) or
// a pixel of the current tile (cmd 1, tile_last on the final pixel), its
// Q8.16 Rec.709 luma summed in the front end. Table writes and finished
// tiles go through a 4-entry queue to the back end, which takes one job at
// a time: a table write as it is popped, a tile by a restoring divide for
// the average, then square, cube, reciprocal scale, clamp and a registered
// table read. Tiles that take longer at the input than in the back end run
// at one pixel per clock; others and write bursts are paced by the back
// end once the queue fills, and in_stall_o then holds the input. A glyph
// table entry must be written before a tile can select it.
module tile_luma_to_glyph import tlg_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       cmd_i,
  input  logic [7:0] table_index_i,
  input  logic [7:0] table_glyph_i,
  input  logic [7:0] red_i,
  input  logic [7:0] green_i,
  input  logic [7:0] blue_i,
  input  logic       tile_last_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] glyph_code_o
);

  logic      push;
  logic      pop;
  q_entry_t  push_entry;
  q_entry_t  head;
  q_status_t q_status;

  tlg_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .cmd_i         (cmd_i),
    .table_index_i (table_index_i),
    .table_glyph_i (table_glyph_i),
    .red_i         (red_i),
    .green_i       (green_i),
    .blue_i        (blue_i),
    .tile_last_i   (tile_last_i),
    .q_status_i    (q_status),
    .push_o        (push),
    .push_entry_o  (push_entry)
  );

  tlg_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .pop_i        (pop),
    .head_o       (head),
    .status_o     (q_status)
  );

  tlg_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .q_status_i   (q_status),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .glyph_code_o (glyph_code_o)
  );

endmodule

>>> rtl/tlg_checker.sv
// Port-level checker for tile_luma_to_glyph, bound to the top level.
// Depends on nothing but the top level's ports.
module tlg_port_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       cmd_i,
  input logic [7:0] table_index_i,
  input logic [7:0] table_glyph_i,
  input logic [7:0] red_i,
  input logic [7:0] green_i,
  input logic [7:0] blue_i,
  input logic       tile_last_i,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] glyph_code_o
);

  // Tiles ended at the input but not yet delivered
  logic [3:0] pending_q, pending_d;
  logic       tile_in, tile_out;

  assign tile_in  = in_valid_i && !in_stall_o && cmd_i && tile_last_i;
  assign tile_out = out_valid_o && !out_stall_i;

  always_comb begin
    pending_d = pending_q;
    if (tile_in && !tile_out) begin
      pending_d = pending_q + 4'd1;
    end else if (tile_out && !tile_in) begin
      pending_d = pending_q - 4'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_d;
    end
  end

  // A result word belongs to a tile already ended
  a_out_has_tile: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pending_q != 4'd0)
    else $error("glyph word with no finished tile");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(glyph_code_o))
    else $error("stalled glyph word changed");

  // Coming out of reset no result shows
  a_reset_quiet: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("result valid straight after reset");

  // Backlog of tiles never exceeds 8
  a_backlog: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q <= 4'd8)
    else $error("too many tiles in flight");

endmodule

bind tile_luma_to_glyph tlg_port_checker u_tlg_checker (.*);
